// ----- sv/first_fit_block_allocator_top_macros.svh -----
// Assertion macros shared by the first-fit allocator checker.
// No dependencies; the including module must provide clk and rst_n.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_TOP_MACROS_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_TOP_MACROS_SVH

// Property checked on every edge outside reset.
`define FFBA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("allocator assertion failed");

// Property checked on every edge, reset cycles included.
`define FFBA_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("allocator assertion failed");

`endif

// ----- sv/ffba_pkg.sv -----
// Package for the first-fit block allocator: sizes, payload types, codes.
// No dependencies.
`default_nettype none

package ffba_pkg;

  localparam int BLOCK_BYTES  = 64;
  localparam int HEAP_BLOCKS  = 1024;
  localparam int MAX_SEGMENTS = 64;

  localparam int BYTES_W     = 16;
  localparam int ADDR_W      = 11;
  localparam int BYTE_SHIFT  = $clog2(BLOCK_BYTES);
  localparam int HEAP_IDX_W  = $clog2(HEAP_BLOCKS);
  localparam int SEG_IDX_W   = $clog2(MAX_SEGMENTS);
  localparam int SEG_CNT_W   = $clog2(MAX_SEGMENTS + 1);
  localparam int NEED_SUM_W  = BYTES_W + 1;
  localparam int NEED_W      = $clog2((65535 + BLOCK_BYTES - 1) / BLOCK_BYTES + 2);
  localparam int SEG_VAL_W   = 32;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK,
    STATUS_BAD_ARG,
    STATUS_NO_FIT,
    STATUS_TABLE_FULL
  } status_t;

  typedef struct packed {
    logic                opcode;
    logic [BYTES_W-1:0]  request_bytes;
    logic [ADDR_W-1:0]   block_address;
  } in_req_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   block_address_out;
    status_t             status;
  } out_rsp_t;

  typedef struct packed {
    logic [SEG_VAL_W-1:0] start;
    logic [SEG_VAL_W-1:0] length;
  } seg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_DROP,
    ST_SHUP,
    ST_INSERT,
    ST_RESP
  } state_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_ACCEPT,
    CMD_CHECK,
    CMD_BAD,
    CMD_NOFIT,
    CMD_FULL,
    CMD_SCAN_STEP,
    CMD_ALLOC_SPLIT,
    CMD_ALLOC_TAKE,
    CMD_FREE_BOTH,
    CMD_FREE_PREV,
    CMD_FREE_NEXT,
    CMD_SHUP_START,
    CMD_SHUP_STEP,
    CMD_DROP_STEP,
    CMD_INSERT
  } cmd_t;

  // Separate flag for the output load so the command set stays one-hot-free.
  typedef struct packed {
    cmd_t cmd;
    logic respond;
  } dp_ctl_t;

  typedef struct packed {
    logic is_free;
    logic bad;
    logic in_range;
    logic fit;
    logic exact;
    logic go_on;
    logic next_adj;
    logic prev_adj;
    logic full;
    logic ins_shift;
    logic drop_needed;
    logic drop_more;
    logic up_more;
    logic out_busy;
  } dp_stat_t;

endpackage

`default_nettype wire

// ----- sv/first_fit_block_allocator_top.sv -----
// First-fit block allocator: top level joining ffba_ctrl and ffba_datapath.
// Flow: a rejected argument goes from check straight to respond; any other request walks
// the table in scan, moves entries in drop or shift-up, adds a new entry in insert as
// needed, and responds; the next request is taken once the controller is idle again.
// Reset (synchronous, rst_n low) restores one free segment covering the heap at
// once; there is no clearing pass. Depends on ffba_pkg.
`default_nettype none

module first_fit_block_allocator_top (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire ffba_pkg::in_req_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output ffba_pkg::out_rsp_t      out_data
);

  // The controller walks the request through check, scan, drop or shift-up, insert
  // and respond phases; the datapath owns the segment table, the per-header length
  // memory and the output register. A finished result waits in the output register,
  // so a new request is taken while an older result is still unclaimed.
  ffba_pkg::dp_ctl_t  ctl;
  ffba_pkg::dp_stat_t stat;

  ffba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .ctl      (ctl)
  );

  ffba_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .ctl       (ctl),
    .stat      (stat)
  );

endmodule

`default_nettype wire

// ----- sv/ffba_ctrl.sv -----
// Controller state machine of the first-fit allocator.
// Depends on ffba_pkg; drives ffba_datapath through dp_ctl_t.
`default_nettype none

module ffba_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire ffba_pkg::dp_stat_t stat,
  output ffba_pkg::dp_ctl_t      ctl
);

  ffba_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ffba_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ffba_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = ffba_pkg::ST_CHECK;
      end
      ffba_pkg::ST_CHECK: begin
        state_nxt = stat.bad ? ffba_pkg::ST_RESP : ffba_pkg::ST_SCAN;
      end
      ffba_pkg::ST_SCAN: begin
        if (!stat.is_free) begin
          if (!stat.in_range) begin
            state_nxt = ffba_pkg::ST_RESP;
          end else if (stat.fit) begin
            state_nxt = (stat.exact && stat.drop_needed) ? ffba_pkg::ST_DROP
                                                         : ffba_pkg::ST_RESP;
          end
        end else if (!stat.go_on) begin
          if (stat.next_adj && stat.prev_adj) begin
            state_nxt = stat.drop_needed ? ffba_pkg::ST_DROP : ffba_pkg::ST_RESP;
          end else if (stat.prev_adj || stat.next_adj || stat.full) begin
            state_nxt = ffba_pkg::ST_RESP;
          end else if (stat.ins_shift) begin
            state_nxt = ffba_pkg::ST_SHUP;
          end else begin
            state_nxt = ffba_pkg::ST_INSERT;
          end
        end
      end
      ffba_pkg::ST_DROP: begin
        if (!stat.drop_more) state_nxt = ffba_pkg::ST_RESP;
      end
      ffba_pkg::ST_SHUP: begin
        if (!stat.up_more) state_nxt = ffba_pkg::ST_INSERT;
      end
      ffba_pkg::ST_INSERT: begin
        state_nxt = ffba_pkg::ST_RESP;
      end
      ffba_pkg::ST_RESP: begin
        if (!stat.out_busy) state_nxt = ffba_pkg::ST_IDLE;
      end
      default: state_nxt = ffba_pkg::ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    ctl.cmd     = ffba_pkg::CMD_NONE;
    ctl.respond = 1'b0;
    in_ready    = 1'b0;
    unique case (state_r)
      ffba_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) ctl.cmd = ffba_pkg::CMD_ACCEPT;
      end
      ffba_pkg::ST_CHECK: begin
        ctl.cmd = stat.bad ? ffba_pkg::CMD_BAD : ffba_pkg::CMD_CHECK;
      end
      ffba_pkg::ST_SCAN: begin
        if (!stat.is_free) begin
          if (!stat.in_range) begin
            ctl.cmd = ffba_pkg::CMD_NOFIT;
          end else if (stat.fit) begin
            ctl.cmd = stat.exact ? ffba_pkg::CMD_ALLOC_TAKE : ffba_pkg::CMD_ALLOC_SPLIT;
          end else begin
            ctl.cmd = ffba_pkg::CMD_SCAN_STEP;
          end
        end else if (stat.go_on) begin
          ctl.cmd = ffba_pkg::CMD_SCAN_STEP;
        end else if (stat.next_adj && stat.prev_adj) begin
          ctl.cmd = ffba_pkg::CMD_FREE_BOTH;
        end else if (stat.prev_adj) begin
          ctl.cmd = ffba_pkg::CMD_FREE_PREV;
        end else if (stat.next_adj) begin
          ctl.cmd = ffba_pkg::CMD_FREE_NEXT;
        end else if (stat.full) begin
          ctl.cmd = ffba_pkg::CMD_FULL;
        end else if (stat.ins_shift) begin
          ctl.cmd = ffba_pkg::CMD_SHUP_START;
        end
      end
      ffba_pkg::ST_DROP:   ctl.cmd = ffba_pkg::CMD_DROP_STEP;
      ffba_pkg::ST_SHUP:   ctl.cmd = ffba_pkg::CMD_SHUP_STEP;
      ffba_pkg::ST_INSERT: ctl.cmd = ffba_pkg::CMD_INSERT;
      ffba_pkg::ST_RESP: begin
        ctl.respond = !stat.out_busy;
      end
      default: ctl.cmd = ffba_pkg::CMD_NONE;
    endcase
  end

endmodule

`default_nettype wire

// ----- sv/ffba_datapath.sv -----
// Datapath of the first-fit allocator: segment table, length memory, result.
// Depends on ffba_pkg; commanded by ffba_ctrl.
`default_nettype none

module ffba_datapath (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire ffba_pkg::in_req_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output ffba_pkg::out_rsp_t      out_data,
  input  wire ffba_pkg::dp_ctl_t  ctl,
  output ffba_pkg::dp_stat_t      stat
);

  // Memories.
  ffba_pkg::seg_t                    seg_mem [ffba_pkg::MAX_SEGMENTS];
  logic [ffba_pkg::NEED_W-1:0]       alen_mem [ffba_pkg::HEAP_BLOCKS];

  ffba_pkg::seg_t                    seg_q_r;
  logic                              rd_zero_r;
  logic                              ent0_wr_r, ent0_wr_nxt;
  logic [ffba_pkg::NEED_W-1:0]       alen_q_r;

  logic                              seg_we;
  logic [ffba_pkg::SEG_IDX_W-1:0]    seg_wa, seg_ra;
  ffba_pkg::seg_t                    seg_wd;
  logic                              alen_we, alen_re;
  logic [ffba_pkg::HEAP_IDX_W-1:0]   alen_wa, alen_ra;

  // Request and walk registers.
  logic                              op_r, op_nxt;
  logic                              bad_r, bad_nxt;
  logic [ffba_pkg::NEED_W-1:0]       need_r, need_nxt;
  logic [ffba_pkg::HEAP_IDX_W-1:0]   h_r, h_nxt;
  logic [ffba_pkg::SEG_CNT_W-1:0]    i_r, i_nxt;
  logic [ffba_pkg::SEG_IDX_W-1:0]    j_r, j_nxt;
  logic [ffba_pkg::SEG_CNT_W-1:0]    cnt_r, cnt_nxt;
  ffba_pkg::seg_t                    prev_r, prev_nxt;
  logic [ffba_pkg::ADDR_W-1:0]       res_addr_r, res_addr_nxt;
  ffba_pkg::status_t                 res_status_r, res_status_nxt;
  logic                              out_valid_r, out_valid_nxt;
  ffba_pkg::out_rsp_t                out_data_r, out_data_nxt;

  // Derived values.
  ffba_pkg::seg_t                    rd;
  logic [ffba_pkg::SEG_VAL_W-1:0]    h32, len32, need32, s_p1;
  logic [ffba_pkg::SEG_VAL_W-1:0]    addr32;
  logic [ffba_pkg::NEED_SUM_W-1:0]   need_sum, need_full;
  logic [ffba_pkg::ADDR_W-1:0]       addr_m1;
  logic [ffba_pkg::SEG_CNT_W-1:0]    i_p1, i_m1, j_ext, j_p1w, cnt_m1;
  logic [ffba_pkg::SEG_IDX_W-1:0]    j_m1;

  always_comb begin
    rd = seg_q_r;
    if (rd_zero_r) begin
      rd.start  = '0;
      rd.length = ffba_pkg::SEG_VAL_W'(ffba_pkg::HEAP_BLOCKS);
    end
  end

  assign h32    = {{(ffba_pkg::SEG_VAL_W - ffba_pkg::HEAP_IDX_W){1'b0}}, h_r};
  assign len32  = {{(ffba_pkg::SEG_VAL_W - ffba_pkg::NEED_W){1'b0}}, alen_q_r};
  assign need32 = {{(ffba_pkg::SEG_VAL_W - ffba_pkg::NEED_W){1'b0}}, need_r};
  assign s_p1   = rd.start + 1'b1;
  assign addr32 = {{(ffba_pkg::SEG_VAL_W - ffba_pkg::ADDR_W){1'b0}}, in_data.block_address};

  assign need_sum  = {1'b0, in_data.request_bytes} +
                     ffba_pkg::NEED_SUM_W'(ffba_pkg::BLOCK_BYTES - 1);
  assign need_full = (need_sum >> ffba_pkg::BYTE_SHIFT) + 1'b1;
  assign addr_m1   = in_data.block_address - 1'b1;

  assign i_p1   = i_r + 1'b1;
  assign i_m1   = i_r - 1'b1;
  assign j_ext  = {1'b0, j_r};
  assign j_p1w  = j_ext + 1'b1;
  assign j_m1   = j_r - 1'b1;
  assign cnt_m1 = cnt_r - 1'b1;

  // Status toward the controller.
  always_comb begin
    stat.is_free     = (op_r == ffba_pkg::OP_FREE);
    stat.bad         = bad_r;
    stat.in_range    = (i_r < cnt_r);
    stat.fit         = (rd.length >= need32);
    stat.exact       = (rd.length == need32);
    stat.go_on       = (i_r < cnt_r) && (rd.start < h32);
    stat.next_adj    = (i_r < cnt_r) && ((h32 + len32) == rd.start);
    stat.prev_adj    = (i_r != '0) && ((prev_r.start + prev_r.length) == h32);
    stat.full        = (cnt_r >= ffba_pkg::SEG_CNT_W'(ffba_pkg::MAX_SEGMENTS));
    stat.ins_shift   = (cnt_r > i_r);
    stat.drop_needed = (i_p1 < cnt_r);
    stat.drop_more   = (j_p1w < cnt_r);
    stat.up_more     = (j_ext > i_r);
    stat.out_busy    = out_valid_r && !out_ready;
  end

  // Command decode.
  always_comb begin
    op_nxt         = op_r;
    bad_nxt        = bad_r;
    need_nxt       = need_r;
    h_nxt          = h_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    cnt_nxt        = cnt_r;
    prev_nxt       = prev_r;
    res_addr_nxt   = res_addr_r;
    res_status_nxt = res_status_r;
    seg_we         = 1'b0;
    seg_wa         = i_r[ffba_pkg::SEG_IDX_W-1:0];
    seg_wd         = rd;
    seg_ra         = i_p1[ffba_pkg::SEG_IDX_W-1:0];
    alen_we        = 1'b0;
    alen_wa        = rd.start[ffba_pkg::HEAP_IDX_W-1:0];
    alen_re        = 1'b0;
    alen_ra        = addr_m1[ffba_pkg::HEAP_IDX_W-1:0];

    unique case (ctl.cmd)
      ffba_pkg::CMD_ACCEPT: begin
        op_nxt   = in_data.opcode;
        need_nxt = need_full[ffba_pkg::NEED_W-1:0];
        h_nxt    = addr_m1[ffba_pkg::HEAP_IDX_W-1:0];
        alen_re  = 1'b1;
        if (in_data.opcode == ffba_pkg::OP_FREE) begin
          bad_nxt = (in_data.block_address == '0) ||
                    (addr32 > ffba_pkg::SEG_VAL_W'(ffba_pkg::HEAP_BLOCKS));
        end else begin
          bad_nxt = (in_data.request_bytes == '0);
        end
      end
      ffba_pkg::CMD_CHECK: begin
        i_nxt  = '0;
        seg_ra = '0;
      end
      ffba_pkg::CMD_BAD: begin
        res_addr_nxt   = '0;
        res_status_nxt = ffba_pkg::STATUS_BAD_ARG;
      end
      ffba_pkg::CMD_NOFIT: begin
        res_addr_nxt   = '0;
        res_status_nxt = ffba_pkg::STATUS_NO_FIT;
      end
      ffba_pkg::CMD_FULL: begin
        res_addr_nxt   = '0;
        res_status_nxt = ffba_pkg::STATUS_TABLE_FULL;
      end
      ffba_pkg::CMD_SCAN_STEP: begin
        prev_nxt = rd;
        i_nxt    = i_p1;
      end
      ffba_pkg::CMD_ALLOC_SPLIT: begin
        seg_we         = 1'b1;
        seg_wd.start   = rd.start + need32;
        seg_wd.length  = rd.length - need32;
        alen_we        = (rd.start < ffba_pkg::SEG_VAL_W'(ffba_pkg::HEAP_BLOCKS));
        res_addr_nxt   = s_p1[ffba_pkg::ADDR_W-1:0];
        res_status_nxt = ffba_pkg::STATUS_OK;
      end
      ffba_pkg::CMD_ALLOC_TAKE: begin
        alen_we        = (rd.start < ffba_pkg::SEG_VAL_W'(ffba_pkg::HEAP_BLOCKS));
        res_addr_nxt   = s_p1[ffba_pkg::ADDR_W-1:0];
        res_status_nxt = ffba_pkg::STATUS_OK;
        if (stat.drop_needed) begin
          j_nxt = i_p1[ffba_pkg::SEG_IDX_W-1:0];
        end else begin
          cnt_nxt = cnt_m1;
        end
      end
      ffba_pkg::CMD_FREE_BOTH: begin
        seg_we         = 1'b1;
        seg_wa         = i_m1[ffba_pkg::SEG_IDX_W-1:0];
        seg_wd.start   = prev_r.start;
        seg_wd.length  = prev_r.length + len32 + rd.length;
        res_addr_nxt   = '0;
        res_status_nxt = ffba_pkg::STATUS_OK;
        if (stat.drop_needed) begin
          j_nxt = i_p1[ffba_pkg::SEG_IDX_W-1:0];
        end else begin
          cnt_nxt = cnt_m1;
        end
      end
      ffba_pkg::CMD_FREE_PREV: begin
        seg_we         = 1'b1;
        seg_wa         = i_m1[ffba_pkg::SEG_IDX_W-1:0];
        seg_wd.start   = prev_r.start;
        seg_wd.length  = prev_r.length + len32;
        res_addr_nxt   = '0;
        res_status_nxt = ffba_pkg::STATUS_OK;
      end
      ffba_pkg::CMD_FREE_NEXT: begin
        seg_we         = 1'b1;
        seg_wd.start   = h32;
        seg_wd.length  = rd.length + len32;
        res_addr_nxt   = '0;
        res_status_nxt = ffba_pkg::STATUS_OK;
      end
      ffba_pkg::CMD_SHUP_START: begin
        j_nxt  = cnt_m1[ffba_pkg::SEG_IDX_W-1:0];
        seg_ra = cnt_m1[ffba_pkg::SEG_IDX_W-1:0];
      end
      ffba_pkg::CMD_SHUP_STEP: begin
        seg_we = 1'b1;
        seg_wa = j_p1w[ffba_pkg::SEG_IDX_W-1:0];
        seg_ra = j_m1;
        if (stat.up_more) j_nxt = j_m1;
      end
      ffba_pkg::CMD_DROP_STEP: begin
        seg_we = 1'b1;
        seg_wa = j_m1;
        seg_ra = j_p1w[ffba_pkg::SEG_IDX_W-1:0];
        if (stat.drop_more) begin
          j_nxt = j_p1w[ffba_pkg::SEG_IDX_W-1:0];
        end else begin
          cnt_nxt = cnt_m1;
        end
      end
      ffba_pkg::CMD_INSERT: begin
        seg_we         = 1'b1;
        seg_wd.start   = h32;
        seg_wd.length  = len32;
        cnt_nxt        = cnt_r + 1'b1;
        res_addr_nxt   = '0;
        res_status_nxt = ffba_pkg::STATUS_OK;
      end
      default: begin
      end
    endcase
  end

  assign ent0_wr_nxt = ent0_wr_r || (seg_we && (seg_wa == '0));

  // Output register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (ctl.respond) begin
      out_valid_nxt                  = 1'b1;
      out_data_nxt.block_address_out = res_addr_r;
      out_data_nxt.status            = res_status_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= ffba_pkg::SEG_CNT_W'(1);
      ent0_wr_r   <= 1'b0;
      rd_zero_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      ent0_wr_r   <= ent0_wr_nxt;
      rd_zero_r   <= (seg_ra == '0) && !ent0_wr_r;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    bad_r        <= bad_nxt;
    need_r       <= need_nxt;
    h_r          <= h_nxt;
    i_r          <= i_nxt;
    j_r          <= j_nxt;
    prev_r       <= prev_nxt;
    res_addr_r   <= res_addr_nxt;
    res_status_r <= res_status_nxt;
    out_data_r   <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (seg_we) seg_mem[seg_wa] <= seg_wd;
    seg_q_r <= seg_mem[seg_ra];
  end

  always_ff @(posedge clk) begin
    if (alen_we) alen_mem[alen_wa] <= need_r;
    if (alen_re) alen_q_r <= alen_mem[alen_ra];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ----- sv/ffba_checker.sv -----
// Port-level checker for the first-fit allocator, bound to the top level.
// Depends on ffba_pkg and first_fit_block_allocator_top_macros.svh.
`default_nettype none
`include "first_fit_block_allocator_top_macros.svh"

module ffba_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire ffba_pkg::in_req_t  in_data,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire ffba_pkg::out_rsp_t out_data
);

  // A stalled result holds still.
  `FFBA_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data))
  // Only a successful request can carry a nonzero address.
  `FFBA_ASSERT(a_fail_null, out_valid && (out_data.status != ffba_pkg::STATUS_OK) |-> (out_data.block_address_out == '0))
  // One request at a time: taking a request closes the input.
  `FFBA_ASSERT(a_one_inflight, in_valid && in_ready |=> !in_ready)
  // Reset empties the output register.
  `FFBA_ASSERT_ALWAYS(a_reset_out, !rst_n |=> !out_valid)

endmodule

bind first_fit_block_allocator_top ffba_checker u_ffba_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
